[rtl/rpnc_pkg.sv]
// Shared types and constants for the RPN stack calculator.
// Holds operation and status codes, port widths and the arithmetic unit request.
// No dependencies.
`timescale 1ns / 1ps

package rpnc_pkg;

    localparam int FUNC_W          = 3;
    localparam int OPERAND_W       = 32;
    localparam int DEPTH_W         = 9;
    localparam int STATUS_W        = 2;
    localparam int DEF_STACK_DEPTH = 256;
    localparam int DEF_DATA_WIDTH  = 32;

    typedef enum logic [FUNC_W-1:0] {
        FN_PUSH = 3'd0,
        FN_ADD  = 3'd1,
        FN_SUB  = 3'd2,
        FN_MUL  = 3'd3,
        FN_DIV  = 3'd4,
        FN_MOD  = 3'd5
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_UNDER   = 2'd1,
        ST_DIVZERO = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ALU_MUL = 2'd0,
        ALU_DIV = 2'd1,
        ALU_REM = 2'd2
    } alu_op_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_req_t;

endpackage

[rtl/rpnc_alu.sv]
// Bit-serial arithmetic unit: shift-add multiply and restoring divide/remainder.
// One bit per cycle in A_RUN, then one cycle with done high.
// Depends on rpnc_pkg.
`timescale 1ns / 1ps

module rpnc_alu #(
    parameter int DATA_WIDTH = rpnc_pkg::DEF_DATA_WIDTH
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  rpnc_pkg::alu_req_t     req,
    input  logic [DATA_WIDTH-1:0]  a,
    input  logic [DATA_WIDTH-1:0]  b,
    output logic                   done,
    output logic [DATA_WIDTH-1:0]  result
);
    import rpnc_pkg::*;

    localparam int CNTW = $clog2(DATA_WIDTH);

    typedef enum logic [1:0] {
        A_IDLE,
        A_RUN,
        A_DONE
    } astate_t;

    astate_t               state_reg, state_next;
    alu_op_t               op_reg, op_next;
    logic [CNTW-1:0]       cnt_reg, cnt_next;
    logic [DATA_WIDTH-1:0] acc_reg, acc_next;
    logic [DATA_WIDTH-1:0] opa_reg, opa_next;
    logic [DATA_WIDTH-1:0] opb_reg, opb_next;
    logic                  neg_q_reg, neg_q_next;
    logic                  neg_r_reg, neg_r_next;

    logic [DATA_WIDTH:0]   shifted;
    logic [DATA_WIDTH:0]   trial;
    logic [DATA_WIDTH-1:0] mag_a;
    logic [DATA_WIDTH-1:0] mag_b;

    assign mag_a   = a[DATA_WIDTH-1] ? (~a + 1'b1) : a;
    assign mag_b   = b[DATA_WIDTH-1] ? (~b + 1'b1) : b;
    // The partial remainder stays below the divisor, so one extra bit covers the shift.
    assign shifted = {acc_reg, opa_reg[DATA_WIDTH-1]};
    assign trial   = shifted - {1'b0, opb_reg};

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        opa_next   = opa_reg;
        opb_next   = opb_reg;
        neg_q_next = neg_q_reg;
        neg_r_next = neg_r_reg;
        case (state_reg)
            A_IDLE:
            begin
                if (req.start)
                begin
                    op_next    = req.op;
                    cnt_next   = CNTW'(DATA_WIDTH - 1);
                    acc_next   = '0;
                    neg_q_next = a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1];
                    neg_r_next = a[DATA_WIDTH-1];
                    if (req.op == ALU_MUL)
                    begin
                        opa_next = a;
                        opb_next = b;
                    end
                    else
                    begin
                        opa_next = mag_a;
                        opb_next = mag_b;
                    end
                    state_next = A_RUN;
                end
            end
            A_RUN:
            begin
                if (op_reg == ALU_MUL)
                begin
                    if (opb_reg[0])
                    begin
                        acc_next = acc_reg + opa_reg;
                    end
                    opa_next = {opa_reg[DATA_WIDTH-2:0], 1'b0};
                    opb_next = {1'b0, opb_reg[DATA_WIDTH-1:1]};
                end
                else if (!trial[DATA_WIDTH])
                begin
                    acc_next = trial[DATA_WIDTH-1:0];
                    opa_next = {opa_reg[DATA_WIDTH-2:0], 1'b1};
                end
                else
                begin
                    acc_next = shifted[DATA_WIDTH-1:0];
                    opa_next = {opa_reg[DATA_WIDTH-2:0], 1'b0};
                end
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = A_DONE;
                end
            end
            A_DONE:
            begin
                state_next = A_IDLE;
            end
            default:
            begin
                state_next = A_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= A_IDLE;
            op_reg    <= ALU_MUL;
            cnt_reg   <= '0;
            acc_reg   <= '0;
            opa_reg   <= '0;
            opb_reg   <= '0;
            neg_q_reg <= 1'b0;
            neg_r_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            cnt_reg   <= cnt_next;
            acc_reg   <= acc_next;
            opa_reg   <= opa_next;
            opb_reg   <= opb_next;
            neg_q_reg <= neg_q_next;
            neg_r_reg <= neg_r_next;
        end
    end

    assign done = (state_reg == A_DONE);

    always_comb
    begin
        case (op_reg)
            ALU_MUL: result = acc_reg;
            ALU_DIV: result = neg_q_reg ? (~opa_reg + 1'b1) : opa_reg;
            ALU_REM: result = neg_r_reg ? (~acc_reg + 1'b1) : acc_reg;
            default: result = acc_reg;
        endcase
    end

endmodule

[rtl/rpn_stack_calculator.sv]
// RPN stack calculator top level: stack memory, sequencer and output register.
// Push, underflow and no-op go from accept straight to S_EMIT; add, subtract and a zero
// divisor pass S_READ first, and multiply, divide and modulo also wait in S_WAIT.
// One item is in work at a time: in_ready rises in the cycle after the result is loaded,
// and S_EMIT holds the result while the previous output beat has not been taken.
// Reset clears the entry count and control; the stack memory is not cleared.
`timescale 1ns / 1ps

module rpn_stack_calculator #(
    parameter int STACK_DEPTH = rpnc_pkg::DEF_STACK_DEPTH,
    parameter int DATA_WIDTH  = rpnc_pkg::DEF_DATA_WIDTH
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [rpnc_pkg::FUNC_W-1:0]          func,
    input  logic signed [rpnc_pkg::OPERAND_W-1:0] operand,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [rpnc_pkg::OPERAND_W-1:0] top_value,
    output logic [rpnc_pkg::DEPTH_W-1:0]         depth,
    output logic [rpnc_pkg::STATUS_W-1:0]        status
);
    import rpnc_pkg::*;

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_WAIT,
        S_EMIT
    } state_t;

    state_t                        state_reg, state_next;
    func_t                         func_reg, func_next;
    status_t                       status_reg, status_next;
    logic [CW-1:0]                 count_reg, count_next;
    logic signed [DATA_WIDTH-1:0]  top_reg, top_next;
    logic [DATA_WIDTH-1:0]         b_reg, b_next;
    logic                          out_valid_reg, out_valid_next;
    logic signed [OPERAND_W-1:0]   out_top_reg, out_top_next;
    logic [DEPTH_W-1:0]            out_depth_reg, out_depth_next;
    status_t                       out_status_reg, out_status_next;

    logic [DATA_WIDTH-1:0]         stack_mem [STACK_DEPTH];
    logic [DATA_WIDTH-1:0]         rd_data_reg;
    logic                          mem_we;
    logic                          mem_re;
    logic [AW-1:0]                 mem_waddr;
    logic [AW-1:0]                 mem_raddr;
    logic [DATA_WIDTH-1:0]         mem_wdata;

    logic [CW-1:0]                 count_m2;
    logic [DATA_WIDTH-1:0]         alu_result;
    logic                          alu_done;
    alu_req_t                      alu_req;
    logic [DATA_WIDTH-1:0]         arith_r;
    logic                          commit;

    assign count_m2 = count_reg - CW'(2);
    assign in_ready = (state_reg == S_IDLE);

    rpnc_alu #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (alu_req),
        .a      (rd_data_reg),
        .b      (b_reg),
        .done   (alu_done),
        .result (alu_result)
    );

    always_comb
    begin
        state_next      = state_reg;
        func_next       = func_reg;
        status_next     = status_reg;
        count_next      = count_reg;
        top_next        = top_reg;
        b_next          = b_reg;
        out_valid_next  = out_valid_reg;
        out_top_next    = out_top_reg;
        out_depth_next  = out_depth_reg;
        out_status_next = out_status_reg;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        mem_waddr       = count_reg[AW-1:0];
        mem_raddr       = count_m2[AW-1:0];
        mem_wdata       = DATA_WIDTH'(operand);
        alu_req.start   = 1'b0;
        alu_req.op      = ALU_MUL;
        arith_r         = '0;
        commit          = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    func_next   = func_t'(func);
                    status_next = ST_OK;
                    state_next  = S_EMIT;
                    case (func_t'(func))
                        FN_PUSH:
                        begin
                            if (count_reg == CW'(STACK_DEPTH))
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                top_next   = DATA_WIDTH'(operand);
                                count_next = count_reg + 1'b1;
                            end
                        end
                        FN_ADD, FN_SUB, FN_MUL, FN_DIV, FN_MOD:
                        begin
                            if (count_reg < CW'(2))
                            begin
                                count_next  = '0;
                                status_next = ST_UNDER;
                            end
                            else
                            begin
                                // The right operand is the cached top; only the left is read.
                                mem_re     = 1'b1;
                                b_next     = top_reg;
                                state_next = S_READ;
                            end
                        end
                        default:
                        begin
                            status_next = ST_OK;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                case (func_reg)
                    FN_ADD:
                    begin
                        arith_r = rd_data_reg + b_reg;
                        commit  = 1'b1;
                    end
                    FN_SUB:
                    begin
                        arith_r = rd_data_reg - b_reg;
                        commit  = 1'b1;
                    end
                    FN_MUL:
                    begin
                        alu_req.start = 1'b1;
                        alu_req.op    = ALU_MUL;
                        state_next    = S_WAIT;
                    end
                    FN_DIV, FN_MOD:
                    begin
                        if (b_reg == '0)
                        begin
                            arith_r     = '0;
                            status_next = ST_DIVZERO;
                            commit      = 1'b1;
                        end
                        else
                        begin
                            alu_req.start = 1'b1;
                            alu_req.op    = (func_reg == FN_DIV) ? ALU_DIV : ALU_REM;
                            state_next    = S_WAIT;
                        end
                    end
                    default:
                    begin
                        state_next = S_EMIT;
                    end
                endcase
            end
            S_WAIT:
            begin
                if (alu_done)
                begin
                    arith_r = alu_result;
                    commit  = 1'b1;
                end
            end
            S_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_top_next    = (count_reg == '0) ? '0 : OPERAND_W'(top_reg);
                    out_depth_next  = DEPTH_W'(count_reg);
                    out_status_next = status_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Two entries collapse into one: the result lands where the left operand was.
        if (commit)
        begin
            mem_we     = 1'b1;
            mem_waddr  = count_m2[AW-1:0];
            mem_wdata  = arith_r;
            top_next   = arith_r;
            count_next = count_reg - 1'b1;
            state_next = S_EMIT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            func_reg       <= FN_PUSH;
            status_reg     <= ST_OK;
            count_reg      <= '0;
            top_reg        <= '0;
            b_reg          <= '0;
            out_valid_reg  <= 1'b0;
            out_top_reg    <= '0;
            out_depth_reg  <= '0;
            out_status_reg <= ST_OK;
        end
        else
        begin
            state_reg      <= state_next;
            func_reg       <= func_next;
            status_reg     <= status_next;
            count_reg      <= count_next;
            top_reg        <= top_next;
            b_reg          <= b_next;
            out_valid_reg  <= out_valid_next;
            out_top_reg    <= out_top_next;
            out_depth_reg  <= out_depth_next;
            out_status_reg <= out_status_next;
        end
    end

    // Reads and writes of one item fall in different cycles, and the next item is read only
    // once S_EMIT lies between it and the last write, so no forwarding is required.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            stack_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= stack_mem[mem_raddr];
        end
    end

    assign out_valid = out_valid_reg;
    assign top_value = out_top_reg;
    assign depth     = out_depth_reg;
    assign status    = out_status_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(STACK_DEPTH))
        else $error("entry count exceeds stack depth");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && func == FN_PUSH && count_reg != CW'(STACK_DEPTH))
        |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("accepted push did not grow the stack");

    a_alu_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        alu_done |-> (state_reg == S_WAIT))
        else $error("arithmetic unit finished outside the wait state");

    a_divzero_top: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_DIVZERO) |-> (top_value == '0))
        else $error("divide by zero beat carries a nonzero top value");

    a_under_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_UNDER) |-> (depth == '0))
        else $error("underflow beat reports a nonempty stack");
`endif

endmodule

[bench/tb.sv]
// Self-checking bench for the RPN stack calculator: directed corner cases, stack fill
// and overflow, then random streams of pushes, operators and unused codes under varying backpressure.
// Depends on rpnc_pkg and rpn_stack_calculator.
`timescale 1ns / 1ps

module tb;

    import rpnc_pkg::*;

    localparam int STACK_DEPTH = DEF_STACK_DEPTH;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 50;
    localparam logic [FUNC_W-1:0] FN_NOP_A = 3'd6;
    localparam logic [FUNC_W-1:0] FN_NOP_B = 3'd7;
    localparam logic signed [OPERAND_W-1:0] MOST_NEG = 32'sh8000_0000;
    localparam logic signed [OPERAND_W-1:0] MOST_POS = 32'sh7FFF_FFFF;

    typedef struct packed {
        logic signed [OPERAND_W-1:0] top;
        logic [DEPTH_W-1:0]          depth;
        status_t                     status;
    } calc_result_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          in_valid = 1'b0;
    logic                          in_ready;
    logic [FUNC_W-1:0]             func = '0;
    logic signed [OPERAND_W-1:0]   operand = '0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic signed [OPERAND_W-1:0]   top_value;
    logic [DEPTH_W-1:0]            depth;
    logic [STATUS_W-1:0]           status;

    // Shadow copy of the calculator state, advanced at every accepted input beat.
    logic signed [OPERAND_W-1:0]   shadow_stack [STACK_DEPTH];
    int unsigned                   shadow_depth = 0;
    calc_result_t                  expected_results [$];
    calc_result_t                  oldest_result;

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned hold_cycles = 0;
    int unsigned failures = 0;
    int unsigned cycle_count = 0;

    rpn_stack_calculator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .func      (func),
        .operand   (operand),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .top_value (top_value),
        .depth     (depth),
        .status    (status)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic calc_result_t apply_item(input logic [FUNC_W-1:0] f,
                                                input logic signed [OPERAND_W-1:0] v);
        logic signed [OPERAND_W-1:0] lhs;
        logic signed [OPERAND_W-1:0] rhs;
        logic signed [OPERAND_W-1:0] res;
        longint                      wide_l;
        longint                      wide_r;
        longint                      wide_res;
        calc_result_t                r;
        r.status = ST_OK;
        case (f)
            FN_PUSH:
            begin
                if (shadow_depth >= STACK_DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    shadow_stack[shadow_depth] = v;
                    shadow_depth++;
                end
            end
            FN_ADD, FN_SUB, FN_MUL, FN_DIV, FN_MOD:
            begin
                if (shadow_depth < 2)
                begin
                    shadow_depth = 0;
                    r.status = ST_UNDER;
                end
                else
                begin
                    rhs = shadow_stack[shadow_depth - 1];
                    lhs = shadow_stack[shadow_depth - 2];
                    shadow_depth -= 2;
                    res = '0;
                    if (f == FN_ADD)
                        res = lhs + rhs;
                    else if (f == FN_SUB)
                        res = lhs - rhs;
                    else if (f == FN_MUL)
                        res = lhs * rhs;
                    else if (rhs == 0)
                        r.status = ST_DIVZERO;
                    else
                    begin
                        // Widen so the most negative value over minus one cannot trap.
                        wide_l = lhs;
                        wide_r = rhs;
                        wide_res = (f == FN_DIV) ? (wide_l / wide_r) : (wide_l % wide_r);
                        res = wide_res[OPERAND_W-1:0];
                    end
                    shadow_stack[shadow_depth] = res;
                    shadow_depth++;
                end
            end
            default:
            begin
            end
        endcase
        r.top = (shadow_depth > 0) ? shadow_stack[shadow_depth - 1] : '0;
        r.depth = shadow_depth[DEPTH_W-1:0];
        return r;
    endfunction

    // Result side: random or held-off ready, and a check of every output beat.
    always @(posedge clk)
    begin
        if (out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result: top %0d depth %0d status %0d",
                         $time, top_value, depth, status);
                failures++;
            end
            else
            begin
                oldest_result = expected_results.pop_front();
                if (top_value !== oldest_result.top)
                begin
                    $display("%0t: top_value mismatch: expected %0d, actual %0d",
                             $time, oldest_result.top, top_value);
                    failures++;
                end
                if (depth !== oldest_result.depth)
                begin
                    $display("%0t: depth mismatch: expected %0d, actual %0d",
                             $time, oldest_result.depth, depth);
                    failures++;
                end
                if (status !== oldest_result.status)
                begin
                    $display("%0t: status mismatch: expected %0d, actual %0d",
                             $time, oldest_result.status, status);
                    failures++;
                end
            end
        end
        if (hold_cycles > 0)
        begin
            hold_cycles--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    task automatic send_item(input logic [FUNC_W-1:0] f,
                             input logic signed [OPERAND_W-1:0] v);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        func <= f;
        operand <= v;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        expected_results.push_back(apply_item(f, v));
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    function automatic logic signed [OPERAND_W-1:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return 0;
            1: return 1;
            2: return -1;
            3: return MOST_NEG;
            4: return MOST_POS;
            5, 6: return $signed($urandom_range(0, 20)) - 10;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [FUNC_W-1:0] pick_operator();
        case ($urandom_range(1, 5))
            1: return FN_ADD;
            2: return FN_SUB;
            3: return FN_MUL;
            4: return FN_DIV;
            default: return FN_MOD;
        endcase
    endfunction

    task automatic test_directed();
        // Operators on an empty stack and on a single entry underflow.
        send_item(FN_ADD, $urandom);
        send_item(FN_PUSH, 5);
        send_item(FN_MUL, 0);
        // Wrapping add and subtract at the extremes.
        send_item(FN_PUSH, MOST_POS);
        send_item(FN_PUSH, 1);
        send_item(FN_ADD, 0);
        send_item(FN_PUSH, 1);
        send_item(FN_SUB, 0);
        // Overflowing multiply.
        send_item(FN_PUSH, MOST_POS);
        send_item(FN_MUL, 0);
        // Most negative value over minus one, quotient and remainder.
        send_item(FN_PUSH, MOST_NEG);
        send_item(FN_PUSH, -1);
        send_item(FN_DIV, 0);
        send_item(FN_PUSH, -1);
        send_item(FN_MOD, 0);
        // Truncation toward zero with a negative dividend.
        send_item(FN_PUSH, -7);
        send_item(FN_PUSH, 2);
        send_item(FN_DIV, 0);
        send_item(FN_PUSH, -7);
        send_item(FN_PUSH, 2);
        send_item(FN_MOD, 0);
        // Division and modulo by zero.
        send_item(FN_PUSH, 0);
        send_item(FN_DIV, 0);
        send_item(FN_PUSH, 0);
        send_item(FN_MOD, 0);
        // Unused codes leave the stack alone.
        send_item(FN_NOP_A, $urandom);
        send_item(FN_NOP_B, $urandom);
    endtask

    task automatic test_fill_overflow();
        int unsigned n;
        n = 0;
        while (shadow_depth < STACK_DEPTH)
        begin
            // A long hold-off on the result side stalls the input after the first 100 pushes of the fill.
            if (n == 100)
                hold_cycles = 400;
            send_item(FN_PUSH, pick_operand());
            n++;
        end
        repeat (4)
            send_item(FN_PUSH, pick_operand());
        while (shadow_depth > 1)
            send_item(pick_operator(), $urandom);
    endtask

    task automatic test_random_mix(input int unsigned count);
        int unsigned sel;
        repeat (count)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 55)
                send_item(FN_PUSH, pick_operand());
            else if (sel < 95)
                send_item(pick_operator(), $urandom);
            else
                send_item($urandom_range(0, 1) ? FN_NOP_A : FN_NOP_B, $urandom);
        end
    endtask

    initial
    begin
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 12;
        recv_idle_pct = 60;
        test_directed();
        test_fill_overflow();
        drain_results();

        send_idle_pct = 60;
        recv_idle_pct = 12;
        test_random_mix(250);
        drain_results();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_mix(250);
        drain_results();

        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (failures == 0 && expected_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

[filelist.f]
rtl/rpnc_pkg.sv
rtl/rpnc_alu.sv
rtl/rpn_stack_calculator.sv
bench/tb.sv
